// ===== rtl/frame_flip_rotate_assert.svh =====
// Assertion macros shared by the frame_flip_rotate RTL.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef FRAME_FLIP_ROTATE_ASSERT_SVH
`define FRAME_FLIP_ROTATE_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define FFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define FFR_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/ffr_pkg.sv =====
// Package for frame_flip_rotate: payload structs, mode codes, register indexes.
// No dependencies.
package ffr_pkg;

    // Input pixel request
    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } in_t;

    // Output pixel request
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       out_valid;
        logic       out_last;
    } out_t;

    // Per-request flags that travel alongside the memory access
    typedef struct packed {
        logic valid;
        logic last;
    } flags_t;

    // Transform modes
    typedef enum logic [1:0] {
        MODE_FLIP_H = 2'd0,
        MODE_FLIP_V = 2'd1,
        MODE_ROT_CW = 2'd2,
        MODE_PASS   = 2'd3
    } mode_t;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFORM_MODE = 2'd2;
    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST   = 7'd64;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST  = 7'd64;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

// ===== rtl/ffr_front.sv =====
// Front end of frame_flip_rotate: config registers, raster counters, address generation.
// Depends on ffr_pkg and frame_flip_rotate_assert.svh.
`include "frame_flip_rotate_assert.svh"

module ffr_front #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  ffr_pkg::in_t                     pixel,
    input  logic                             pop_done,
    input  logic                             cfg_we,
    input  logic [ffr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ffr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             req_valid,
    output logic [$clog2(2*MAX_WIDTH*MAX_HEIGHT)-1:0] rd_addr,
    output logic [$clog2(2*MAX_WIDTH*MAX_HEIGHT)-1:0] wr_addr,
    output ffr_pkg::in_t                     wr_data,
    output ffr_pkg::flags_t                  req_flags
);

    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SZ_W    = $clog2(MAX_DIM + 1);
    localparam int BANK    = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = $clog2(2 * BANK);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);
    localparam logic [AW-1:0] BANK_BASE  = AW'(BANK);

    // Configuration registers
    logic [ffr_pkg::CFG_DATA_W-1:0] frame_width_reg, frame_height_reg;
    ffr_pkg::mode_t                 mode_reg;

    // Raster and frame state
    logic [SZ_W-1:0] wr_col_reg, wr_col_next, wr_row_reg, wr_row_next;
    logic [SZ_W-1:0] rd_col_reg, rd_col_next, rd_row_reg, rd_row_next;
    logic            bank_reg, bank_next;
    logic            ready_reg, ready_next;
    logic [ffr_pkg::QCNT_W-1:0] credit_reg, credit_next;

    // Request register toward the store
    logic                 req_valid_reg;
    logic [AW-1:0]        rd_addr_reg, rd_addr_next;
    logic [AW-1:0]        wr_addr_reg, wr_addr_next;
    ffr_pkg::in_t         wr_data_reg;
    ffr_pkg::flags_t      flags_reg, flags_next;

    logic            accept;
    logic [SZ_W-1:0] w_c, h_c, ow, oh, rc, rr, sr, sc;
    logic            wr_col_end, wr_row_end, rd_col_end, rd_row_end;

    assign accept = push && !full;
    assign full   = (credit_reg == ffr_pkg::QCNT_W'(ffr_pkg::QDEPTH));

    // Clamp the configured size into 1..MAX
    always_comb
    begin
        if (frame_width_reg == '0)
            w_c = SZ_W'(1);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            w_c = SZ_W'(MAX_WIDTH);
        else
            w_c = SZ_W'(frame_width_reg);

        if (frame_height_reg == '0)
            h_c = SZ_W'(1);
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
            h_c = SZ_W'(MAX_HEIGHT);
        else
            h_c = SZ_W'(frame_height_reg);
    end

    // Output frame geometry and clamped read coordinates
    assign ow = (mode_reg == ffr_pkg::MODE_ROT_CW) ? h_c : w_c;
    assign oh = (mode_reg == ffr_pkg::MODE_ROT_CW) ? w_c : h_c;
    assign rc = (rd_col_reg < ow) ? rd_col_reg : ow - SZ_W'(1);
    assign rr = (rd_row_reg < oh) ? rd_row_reg : oh - SZ_W'(1);

    // Map output position to source position
    always_comb
    begin
        case (mode_reg)
            ffr_pkg::MODE_FLIP_H:
            begin
                sr = rr;
                sc = w_c - SZ_W'(1) - rc;
            end
            ffr_pkg::MODE_FLIP_V:
            begin
                sr = h_c - SZ_W'(1) - rr;
                sc = rc;
            end
            ffr_pkg::MODE_ROT_CW:
            begin
                sr = h_c - SZ_W'(1) - rc;
                sc = rr;
            end
            default:
            begin
                sr = rr;
                sc = rc;
            end
        endcase
    end

    // Wrap detection for both raster counters
    assign wr_col_end = ((SZ_W+1)'(wr_col_reg) + (SZ_W+1)'(1)) >= (SZ_W+1)'(w_c);
    assign wr_row_end = ((SZ_W+1)'(wr_row_reg) + (SZ_W+1)'(1)) >= (SZ_W+1)'(h_c);
    assign rd_col_end = ((SZ_W+1)'(rd_col_reg) + (SZ_W+1)'(1)) >= (SZ_W+1)'(ow);
    assign rd_row_end = ((SZ_W+1)'(rd_row_reg) + (SZ_W+1)'(1)) >= (SZ_W+1)'(oh);

    // Addresses: read from the idle bank, write into the active one
    always_comb
    begin
        rd_addr_next = AW'(sr) * ROW_STRIDE + AW'(sc) + (bank_reg ? '0 : BANK_BASE);
        wr_addr_next = AW'(wr_row_reg) * ROW_STRIDE + AW'(wr_col_reg)
                     + (bank_reg ? BANK_BASE : '0);
        flags_next.valid = ready_reg;
        flags_next.last  = ready_reg && rd_col_end && rd_row_end;
    end

    // Counter and bank update per accepted request
    always_comb
    begin
        wr_col_next = wr_col_reg;
        wr_row_next = wr_row_reg;
        rd_col_next = rd_col_reg;
        rd_row_next = rd_row_reg;
        bank_next   = bank_reg;
        ready_next  = ready_reg;
        if (accept)
        begin
            if (wr_col_end && wr_row_end)
            begin
                wr_col_next = '0;
                wr_row_next = '0;
                bank_next   = !bank_reg;
                ready_next  = 1'b1;
                rd_col_next = '0;
                rd_row_next = '0;
            end
            else
            begin
                if (wr_col_end)
                begin
                    wr_col_next = '0;
                    wr_row_next = wr_row_reg + SZ_W'(1);
                end
                else
                begin
                    wr_col_next = wr_col_reg + SZ_W'(1);
                end
                if (rd_col_end)
                begin
                    rd_col_next = '0;
                    rd_row_next = rd_row_end ? '0 : rd_row_reg + SZ_W'(1);
                end
                else
                begin
                    rd_col_next = rd_col_reg + SZ_W'(1);
                end
            end
        end
    end

    // Credits: requests accepted but not yet popped
    always_comb
    begin
        credit_next = credit_reg;
        if (accept && !pop_done)
            credit_next = credit_reg + ffr_pkg::QCNT_W'(1);
        else if (!accept && pop_done)
            credit_next = credit_reg - ffr_pkg::QCNT_W'(1);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= ffr_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= ffr_pkg::FRAME_HEIGHT_RST;
            mode_reg         <= ffr_pkg::MODE_FLIP_H;
            wr_col_reg       <= '0;
            wr_row_reg       <= '0;
            rd_col_reg       <= '0;
            rd_row_reg       <= '0;
            bank_reg         <= 1'b0;
            ready_reg        <= 1'b0;
            credit_reg       <= '0;
            req_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ffr_pkg::CFG_FRAME_WIDTH:    frame_width_reg  <= cfg_data;
                    ffr_pkg::CFG_FRAME_HEIGHT:   frame_height_reg <= cfg_data;
                    ffr_pkg::CFG_TRANSFORM_MODE: mode_reg <= ffr_pkg::mode_t'(cfg_data[1:0]);
                    default: ;
                endcase
            end
            wr_col_reg    <= wr_col_next;
            wr_row_reg    <= wr_row_next;
            rd_col_reg    <= rd_col_next;
            rd_row_reg    <= rd_row_next;
            bank_reg      <= bank_next;
            ready_reg     <= ready_next;
            credit_reg    <= credit_next;
            req_valid_reg <= accept;
        end
    end

    // Request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_addr_reg <= rd_addr_next;
            wr_addr_reg <= wr_addr_next;
            wr_data_reg <= pixel;
            flags_reg   <= flags_next;
        end
    end

    assign req_valid = req_valid_reg;
    assign rd_addr   = rd_addr_reg;
    assign wr_addr   = wr_addr_reg;
    assign wr_data   = wr_data_reg;
    assign req_flags = flags_reg;

    // Checks
    `FFR_ASSERT(a_credit_bound, (credit_reg <= ffr_pkg::QCNT_W'(ffr_pkg::QDEPTH)), "credit overrun")
    `FFR_ASSERT(a_ready_sticky, ready_reg |=> ready_reg, "frame ready dropped")
    `FFR_ASSERT(a_bank_swap, (accept && wr_col_end && wr_row_end) |=> (bank_reg != $past(bank_reg)), "bank did not swap at frame end")

endmodule

// ===== rtl/ffr_store.sv =====
// Ping-pong frame store of frame_flip_rotate: one write and one read per request.
// Depends on ffr_pkg.
module ffr_store #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic [$clog2(2*MAX_WIDTH*MAX_HEIGHT)-1:0] rd_addr,
    input  logic [$clog2(2*MAX_WIDTH*MAX_HEIGHT)-1:0] wr_addr,
    input  ffr_pkg::in_t         wr_data,
    input  ffr_pkg::flags_t      req_flags,
    output logic                 q_push,
    output ffr_pkg::out_t        q_data
);

    localparam int DEPTH = 2 * MAX_WIDTH * MAX_HEIGHT;

    ffr_pkg::in_t    mem [DEPTH];
    ffr_pkg::in_t    rd_data_reg;
    ffr_pkg::flags_t flags_reg;
    logic            valid_reg;

    // Memory access; banks differ so read and write never collide
    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            mem[wr_addr] <= wr_data;
            rd_data_reg  <= mem[rd_addr];
            flags_reg    <= req_flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= req_valid;
    end

    // Blank the pixel while the first frame loads
    always_comb
    begin
        q_data.out_red   = flags_reg.valid ? rd_data_reg.in_red   : 8'd0;
        q_data.out_green = flags_reg.valid ? rd_data_reg.in_green : 8'd0;
        q_data.out_blue  = flags_reg.valid ? rd_data_reg.in_blue  : 8'd0;
        q_data.out_valid = flags_reg.valid;
        q_data.out_last  = flags_reg.last;
    end

    assign q_push = valid_reg;

endmodule

// ===== rtl/ffr_queue.sv =====
// Result queue of frame_flip_rotate: small FIFO between store and result port.
// Depends on ffr_pkg and frame_flip_rotate_assert.svh.
`include "frame_flip_rotate_assert.svh"

module ffr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_push,
    input  ffr_pkg::out_t q_data,
    input  logic          pop,
    output logic          empty,
    output ffr_pkg::out_t result
);

    ffr_pkg::out_t                q_mem [ffr_pkg::QDEPTH];
    logic [ffr_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [ffr_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                         do_pop;

    assign empty  = (cnt_reg == '0);
    assign do_pop = pop && !empty;
    assign result = q_mem[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (q_push && !do_pop)
            cnt_next = cnt_reg + ffr_pkg::QCNT_W'(1);
        else if (!q_push && do_pop)
            cnt_next = cnt_reg - ffr_pkg::QCNT_W'(1);
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (q_push)
                wr_ptr_reg <= wr_ptr_reg + ffr_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + ffr_pkg::QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (q_push)
            q_mem[wr_ptr_reg] <= q_data;
    end

    // Checks
    `FFR_NEVER(a_no_overflow, q_push && !do_pop && (cnt_reg == ffr_pkg::QCNT_W'(ffr_pkg::QDEPTH)), "result queue overflow")
    `FFR_ASSERT(a_push_visible, q_push |=> !empty, "pushed request not visible")
    `FFR_ASSERT(a_ptr_track, (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "pointers disagree with count")

endmodule

// ===== rtl/frame_flip_rotate.sv =====
// Top level of frame_flip_rotate: streaming flip / rotate over a ping-pong frame store.
// Depends on ffr_pkg, ffr_front, ffr_store, ffr_queue.
//
//   Port group         Direction  Handshake        Payload
//   pixel              in         push / full      ffr_pkg::in_t
//   result             out        pop / empty      ffr_pkg::out_t
//   cfg                in         cfg_we           cfg_index, cfg_data
//
// One pixel per clock sustained while full is low; an accepted pixel's
// result is on the result ports after the request register, the registered
// memory read, then the queue write.
// full rises only when four requests are accepted but not popped; the result
// queue holds four entries. Reset clears counters, bank select and queue; the
// frame store needs no clearing. Config writes take effect on the next edge.
module frame_flip_rotate #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  ffr_pkg::in_t                   pixel,
    input  logic                           pop,
    output logic                           empty,
    output ffr_pkg::out_t                  result,
    input  logic                           cfg_we,
    input  logic [ffr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffr_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(2 * MAX_WIDTH * MAX_HEIGHT);

    logic            req_valid;
    logic [AW-1:0]   rd_addr, wr_addr;
    ffr_pkg::in_t    wr_data;
    ffr_pkg::flags_t req_flags;
    logic            q_push;
    ffr_pkg::out_t   q_data;
    logic            pop_done;

    assign pop_done = pop && !empty;

    // Front: config, counters, addresses
    ffr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .pop_done  (pop_done),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .req_flags (req_flags)
    );

    // Frame store
    ffr_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .req_flags (req_flags),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    // Result queue
    ffr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_data (q_data),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

endmodule

// ===== bench/tb_frame_flip_rotate.sv =====
// Self-checking testbench for frame_flip_rotate: random pixel stream, config phases, scoreboard.
// Depends on ffr_pkg and the frame_flip_rotate RTL; predicts each pixel from its own copy
// of the ping-pong frame store, the raster counters and the config registers.
`timescale 1ns / 1ps

module tb_frame_flip_rotate;

    localparam int MAX_W      = 64;
    localparam int MAX_H      = 64;
    localparam int BANK_WORDS = MAX_W * MAX_H;
    localparam int RANDOM_PIXELS = 1360;
    localparam logic [23:0] EXTREME_PX [0:6] = '{24'h000000, 24'hFFFFFF, 24'hFF0000,
        24'h00FF00, 24'h0000FF, 24'hAAAAAA, 24'h555555};

    typedef struct packed {
        bit wrapped;
        int col;
        int row;
    } raster_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    ffr_pkg::in_t pixel = '0;
    logic pop = 1'b0;
    logic empty;
    ffr_pkg::out_t result;
    logic cfg_we = 1'b0;
    logic [ffr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ffr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Pixel requests waiting to be pushed, and predicted output pixels
    ffr_pkg::in_t pixel_backlog[$];
    ffr_pkg::out_t expected_pixels[$];
    int unsigned sender_idle_pct = 28;
    int unsigned receiver_idle_pct = 71;
    int unsigned fail_count = 0;

    // Predictor state: frame store, raster counters, bank select, config copy
    logic [23:0] frame_mem [0:2*BANK_WORDS-1];
    int wr_col = 0, wr_row = 0, rd_col = 0, rd_row = 0;
    bit write_bank = 1'b0;
    bit frame_ready = 1'b0;
    logic [6:0] width_cfg = ffr_pkg::FRAME_WIDTH_RST;
    logic [6:0] height_cfg = ffr_pkg::FRAME_HEIGHT_RST;
    ffr_pkg::mode_t mode_cfg = ffr_pkg::MODE_FLIP_H;

    frame_flip_rotate u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Out-of-range sizes saturate into 1..lim
    function automatic int dim_eff(input logic [6:0] raw, input int lim);
        if (raw == 7'd0)
            return 1;
        if (int'(raw) > lim)
            return lim;
        return int'(raw);
    endfunction

    // Step a raster position; a counter at or past the last position wraps
    function automatic raster_t raster_next(input int col, input int row,
                                            input int cols, input int rows);
        raster_t nx;
        nx.wrapped = 1'b0;
        nx.col = col + 1;
        nx.row = row;
        if (col + 1 >= cols)
        begin
            nx.col = 0;
            if (row + 1 >= rows)
            begin
                nx.row = 0;
                nx.wrapped = 1'b1;
            end
            else
            begin
                nx.row = row + 1;
            end
        end
        return nx;
    endfunction

    // One pixel in: read the previous frame through the transform, write the current one
    function automatic ffr_pkg::out_t predict_flip_rotate(input ffr_pkg::in_t px);
        int w, h, ow, oh, rc, rr, sr, sc;
        logic [23:0] stored;
        ffr_pkg::out_t res;
        raster_t nx;
        w = dim_eff(width_cfg, MAX_W);
        h = dim_eff(height_cfg, MAX_H);
        ow = (mode_cfg == ffr_pkg::MODE_ROT_CW) ? h : w;
        oh = (mode_cfg == ffr_pkg::MODE_ROT_CW) ? w : h;
        rc = (rd_col < ow) ? rd_col : ow - 1;
        rr = (rd_row < oh) ? rd_row : oh - 1;
        case (mode_cfg)
            ffr_pkg::MODE_FLIP_H:
            begin
                sr = rr;
                sc = w - 1 - rc;
            end
            ffr_pkg::MODE_FLIP_V:
            begin
                sr = h - 1 - rr;
                sc = rc;
            end
            ffr_pkg::MODE_ROT_CW:
            begin
                sr = h - 1 - rc;
                sc = rr;
            end
            default:
            begin
                sr = rr;
                sc = rc;
            end
        endcase
        stored = frame_mem[(write_bank ? 0 : BANK_WORDS) + sr * MAX_W + sc];
        res = '0;
        if (frame_ready)
        begin
            {res.out_red, res.out_green, res.out_blue} = stored;
            res.out_valid = 1'b1;
            res.out_last = (rd_col + 1 >= ow) && (rd_row + 1 >= oh);
        end
        frame_mem[(write_bank ? BANK_WORDS : 0) + wr_row * MAX_W + wr_col] = px;
        nx = raster_next(wr_col, wr_row, w, h);
        wr_col = nx.col;
        wr_row = nx.row;
        // frame end: swap banks and restart the readout
        if (nx.wrapped)
        begin
            write_bank = !write_bank;
            frame_ready = 1'b1;
            rd_col = 0;
            rd_row = 0;
        end
        else
        begin
            nx = raster_next(rd_col, rd_row, ow, oh);
            rd_col = nx.col;
            rd_row = nx.row;
        end
        return res;
    endfunction

    function automatic string fmt_pixel(input ffr_pkg::out_t p);
        return $sformatf("rgb=%02h%02h%02h valid=%0b last=%0b",
                         p.out_red, p.out_green, p.out_blue, p.out_valid, p.out_last);
    endfunction

    task automatic log_failure(input string msg);
        if (fail_count < 10)
            $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Pixel request side: accept at the rising edge, drive at the falling edge
    always @(posedge clk)
    begin : accept_side
        if (rst_n && push && !full)
        begin
            expected_pixels.push_back(predict_flip_rotate(pixel));
            void'(pixel_backlog.pop_front());
        end
    end

    always @(negedge clk)
    begin : drive_side
        if (pixel_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
        begin
            push <= 1'b1;
            pixel <= pixel_backlog[0];
        end
        else
        begin
            push <= 1'b0;
        end
    end

    // Result side: random pop stalls, compare each popped pixel with the oldest prediction
    always @(negedge clk)
    begin : pop_side
        pop <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin : check_side
        ffr_pkg::out_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_pixels.size() == 0)
            begin
                log_failure({"result with no request pending: ", fmt_pixel(result)});
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (result.out_red !== want.out_red || result.out_green !== want.out_green ||
                    result.out_blue !== want.out_blue || result.out_valid !== want.out_valid ||
                    result.out_last !== want.out_last)
                    log_failure({"pixel mismatch: expected ", fmt_pixel(want),
                                 ", got ", fmt_pixel(result)});
            end
        end
    end

    // Register write; the copy is updated now since no request is in flight
    task automatic write_reg(input logic [ffr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ffr_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            ffr_pkg::CFG_FRAME_WIDTH: width_cfg = value;
            ffr_pkg::CFG_FRAME_HEIGHT: height_cfg = value;
            default: mode_cfg = ffr_pkg::mode_t'(value[1:0]);
        endcase
    endtask

    task automatic end_reg_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_frame(input logic [6:0] w, input logic [6:0] h,
                             input ffr_pkg::mode_t m);
        write_reg(ffr_pkg::CFG_FRAME_WIDTH, w);
        write_reg(ffr_pkg::CFG_FRAME_HEIGHT, h);
        write_reg(ffr_pkg::CFG_TRANSFORM_MODE, {5'd0, m});
        end_reg_writes();
    endtask

    task automatic queue_pixels(input int count);
        for (int i = 0; i < count; i++)
            pixel_backlog.push_back(ffr_pkg::in_t'(24'($urandom())));
    endtask

    // Block until every queued request is accepted and every result popped
    task automatic wait_for_drain();
        while (pixel_backlog.size() != 0 || expected_pixels.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [6:0] new_w, new_h;
        bit wrote;
        int stage, count, sent, guard;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Two loading frames in pass mode so both banks hold the full top row, the
        // 8x8 corner and the two leftmost columns; every later size stays inside that,
        // so no readout touches a store entry that was never written.
        for (int f = 0; f < 2; f++)
        begin
            set_frame(7'd64, 7'd64, ffr_pkg::MODE_PASS);
            if (f == 0)
            begin
                for (int i = 0; i < 7; i++)
                    pixel_backlog.push_back(ffr_pkg::in_t'(EXTREME_PX[i]));
                queue_pixels(57);
            end
            else
            begin
                queue_pixels(64);
            end
            wait_for_drain();
            set_frame(7'd8, 7'd64, ffr_pkg::MODE_PASS);
            queue_pixels(56);
            wait_for_drain();
            set_frame(7'd2, 7'd64, ffr_pkg::MODE_PASS);
            queue_pixels(112);
            wait_for_drain();
        end

        // Directed: each mode on whole small frames, rotation of a non-square frame,
        // zero sizes saturating to one
        set_frame(7'd2, 7'd1, ffr_pkg::MODE_ROT_CW);
        queue_pixels(2);
        wait_for_drain();
        set_frame(7'd2, 7'd2, ffr_pkg::MODE_FLIP_H);
        queue_pixels(4);
        wait_for_drain();
        set_frame(7'd2, 7'd2, ffr_pkg::MODE_FLIP_V);
        queue_pixels(4);
        wait_for_drain();
        set_frame(7'd2, 7'd2, ffr_pkg::MODE_PASS);
        queue_pixels(4);
        wait_for_drain();
        set_frame(7'd2, 7'd3, ffr_pkg::MODE_ROT_CW);
        queue_pixels(6);
        wait_for_drain();
        set_frame(7'd0, 7'd0, ffr_pkg::MODE_FLIP_H);
        queue_pixels(2);
        wait_for_drain();

        // Random phases; phase lengths ignore frame boundaries, so sizes change mid-frame
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            stage = sent * 3 / RANDOM_PIXELS;
            sender_idle_pct = (stage == 0) ? 28 : (stage == 1) ? 71 : 0;
            receiver_idle_pct = (stage == 0) ? 71 : (stage == 1) ? 28 : 0;
            case ($urandom_range(2))
                0:
                begin
                    new_w = ($urandom_range(3) == 0) ? 7'd127 : 7'($urandom_range(127));
                    new_h = 7'($urandom_range(1));
                end
                1:
                begin
                    new_w = 7'($urandom_range(2));
                    new_h = ($urandom_range(3) == 0) ? 7'd127 : 7'($urandom_range(127));
                end
                default:
                begin
                    new_w = 7'($urandom_range(8));
                    new_h = 7'($urandom_range(8));
                end
            endcase
            wrote = 1'b0;
            if (new_w != width_cfg || $urandom_range(3) == 0)
            begin
                write_reg(ffr_pkg::CFG_FRAME_WIDTH, new_w);
                wrote = 1'b1;
            end
            if (new_h != height_cfg || $urandom_range(3) == 0)
            begin
                write_reg(ffr_pkg::CFG_FRAME_HEIGHT, new_h);
                wrote = 1'b1;
            end
            if ($urandom_range(1) == 1)
            begin
                write_reg(ffr_pkg::CFG_TRANSFORM_MODE, {5'd0, 2'($urandom_range(3))});
                wrote = 1'b1;
            end
            if (wrote)
                end_reg_writes();
            count = ($urandom_range(9) == 0) ? $urandom_range(140, 80) : $urandom_range(40, 1);
            queue_pixels(count);
            sent += count;
            wait_for_drain();
        end

        // Let any stray result show up, then settle the verdict
        guard = 0;
        while (expected_pixels.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);
        if (expected_pixels.size() != 0)
            log_failure($sformatf("%0d results never arrived", expected_pixels.size()));
        if (fail_count == 0)
            $display("PASS frame_flip_rotate");
        else
            $display("FAIL frame_flip_rotate");
        $finish;
    end

    // Hang guard
    initial
    begin : watchdog
        #2_000_000;
        $display("FAIL frame_flip_rotate");
        $finish;
    end

endmodule
